### src/csr_row_dense_expand_dual_count_assert.svh
// Assertion macros used by the back end of the sparse row expander RTL.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef CSR_ROW_DENSE_EXPAND_DUAL_COUNT_ASSERT_SVH
`define CSR_ROW_DENSE_EXPAND_DUAL_COUNT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define CRDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CRDE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CRDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRDE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### src/crde_pkg.sv
// Types and constants of the sparse row expander: payload structs, the queued
// run descriptor, operation, value kind and register codes. No dependencies.
`default_nettype none

package crde_pkg;

    localparam int COLUMN_LIMIT = 64;

    // Operation codes of the input item
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // Value kinds; any other code selects the dual count
    localparam logic [1:0] VK_PULSE     = 2'd0;
    localparam logic [1:0] VK_INTENSITY = 2'd1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_NUM_MARKERS     = 2'd0;
    localparam logic [1:0] REG_VALUE_KIND      = 2'd1;
    localparam logic [1:0] REG_PULSE_THRESHOLD = 2'd2;

    localparam logic [6:0]  RST_NUM_MARKERS     = 7'd64;
    localparam logic [1:0]  RST_VALUE_KIND      = 2'd2;
    localparam logic [31:0] RST_PULSE_THRESHOLD = 32'd0;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         marker;
        logic [15:0]        pulse_count;
        logic [15:0]        intensity;
        logic               end_of_push;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         column;
        logic signed [39:0] value;
        logic               row_end;
        logic               run_end;
        logic               order_error;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  num_markers;
        logic [1:0]  value_kind;
        logic [31:0] pulse_threshold;
    } cfg_t;

    typedef enum logic {
        DK_LOAD,
        DK_RUN
    } desc_kind_t;

    // One unit of work for the back end: a calibration write, or a run of
    // dense columns first..last with an optional entry value at marker.
    typedef struct packed {
        desc_kind_t         kind;
        logic [5:0]         first;
        logic [5:0]         last;
        logic               has_entry;
        logic               err;
        logic               flag;
        logic [6:0]         row_len;
        logic [5:0]         marker;
        logic [15:0]        pulse_count;
        logic [15:0]        intensity;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
    } desc_t;

endpackage

`default_nettype wire

### src/crde_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on crde_pkg for the descriptor type.
`default_nettype none

module crde_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  crde_pkg::desc_t   push_data,
    input  wire               pop,
    output crde_pkg::desc_t   head,
    output logic              full,
    output logic              empty
);
    import crde_pkg::*;

    desc_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/crde_front.sv
// Front end: accepts input items, tracks the next dense column of the push
// and turns items into load and run descriptors. Depends on crde_pkg.
`default_nettype none

module crde_front #(
    parameter int MAX_MARKERS = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  crde_pkg::cfg_t     cfg,
    input  wire                in_valid,
    input  crde_pkg::in_item_t in_data,
    input  wire                q_full,
    output logic               in_stall,
    output logic               q_push,
    output crde_pkg::desc_t    q_data
);
    import crde_pkg::*;

    localparam int ROW_LIMIT = (MAX_MARKERS < COLUMN_LIMIT) ? MAX_MARKERS : COLUMN_LIMIT;

    logic [6:0] next_col_reg;
    logic [6:0] next_col_next;
    logic [6:0] row_len;
    logic [6:0] marker_ext;
    logic [6:0] last_col;
    logic       accept;
    logic       is_entry;
    logic       err;
    logic       has_entry;
    logic       close;
    logic       nonempty;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (cfg.num_markers == 7'd0)
        begin
            row_len = 7'd1;
        end
        else if (cfg.num_markers > 7'(ROW_LIMIT))
        begin
            row_len = 7'(ROW_LIMIT);
        end
        else
        begin
            row_len = cfg.num_markers;
        end
    end

    assign marker_ext = {1'b0, in_data.marker};
    assign is_entry   = (in_data.operation == OP_ENTRY);
    assign err        = is_entry && ((marker_ext < next_col_reg) || (marker_ext >= row_len));
    assign has_entry  = is_entry && !err;
    assign close      = (in_data.operation == OP_CLOSE) || (is_entry && in_data.end_of_push);
    assign nonempty   = has_entry || (close && (next_col_reg < row_len));
    assign last_col   = close ? (row_len - 7'd1) : marker_ext;

    always_comb
    begin
        q_data.kind        = DK_RUN;
        q_data.first       = next_col_reg[5:0];
        q_data.last        = last_col[5:0];
        q_data.has_entry   = has_entry;
        q_data.err         = err;
        q_data.flag        = 1'b0;
        q_data.row_len     = row_len;
        q_data.marker      = in_data.marker;
        q_data.pulse_count = in_data.pulse_count;
        q_data.intensity   = in_data.intensity;
        q_data.slope       = in_data.slope;
        q_data.intercept   = in_data.intercept;
        q_push             = 1'b0;
        next_col_next      = next_col_reg;
        case (in_data.operation)
            OP_LOAD:
            begin
                q_data.kind = DK_LOAD;
                q_push      = accept && (int'(in_data.marker) < MAX_MARKERS);
            end
            OP_ENTRY, OP_CLOSE:
            begin
                if (nonempty)
                begin
                    q_push = accept;
                end
                else if (err)
                begin
                    // lone flag result at the dropped marker
                    q_data.first = in_data.marker;
                    q_data.last  = in_data.marker;
                    q_data.flag  = 1'b1;
                    q_push       = accept;
                end
                if (close)
                begin
                    next_col_next = 7'd0;
                end
                else if (has_entry)
                begin
                    next_col_next = marker_ext + 7'd1;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_col_reg <= 7'd0;
        end
        else if (accept)
        begin
            next_col_reg <= next_col_next;
        end
    end

endmodule

`default_nettype wire

### src/crde_back.sv
// Back end: holds the calibration tables, computes entry values and emits the
// dense columns of each run through the output register. Depends on crde_pkg.
`default_nettype none

`include "csr_row_dense_expand_dual_count_assert.svh"

module crde_back #(
    parameter int MAX_MARKERS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  crde_pkg::cfg_t      cfg,
    input  crde_pkg::desc_t     q_head,
    input  wire                 q_empty,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output crde_pkg::out_item_t out_data
);
    import crde_pkg::*;

    localparam int AW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int PW = 49;
    localparam int DW = 50;
    localparam logic signed [DW-1:0] SAT_HI = {{(DW-39){1'b0}}, {39{1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO = {{(DW-39){1'b1}}, {39{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SEL,
        ST_EMIT
    } state_t;

    logic signed [31:0] slope_mem     [MAX_MARKERS];
    logic signed [31:0] intercept_mem [MAX_MARKERS];

    state_t             state_reg;
    desc_t              desc_reg;
    logic [5:0]         col_reg;
    logic signed [31:0] rd_slope_reg;
    logic signed [31:0] rd_icpt_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW-1:0] dual_reg;
    logic signed [39:0] val_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [AW+5:0]      head_ext;
    logic [AW-1:0]      head_idx;
    logic               mem_wr;
    logic               out_load;
    logic               emit_now;
    logic [31:0]        p32;
    logic signed [DW-1:0] p_wide;
    logic signed [39:0] val_next;
    logic [6:0]         col_ext;

    assign head_ext  = {{AW{1'b0}}, q_head.marker};
    assign head_idx  = head_ext[AW-1:0];
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign mem_wr    = q_pop && (q_head.kind == DK_LOAD);
    assign out_load  = !out_valid_reg || !out_stall;
    assign emit_now  = (state_reg == ST_EMIT) && out_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign col_ext   = {1'b0, col_reg};

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            slope_mem[head_idx]     <= q_head.slope;
            intercept_mem[head_idx] <= q_head.intercept;
        end
    end

    // read at the head marker as the run is taken
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_slope_reg <= slope_mem[head_idx];
            rd_icpt_reg  <= intercept_mem[head_idx];
        end
    end

    // pick the entry value by value kind: pulse count, intensity or the dual count
    assign p32    = {desc_reg.pulse_count, 16'd0};
    assign p_wide = $signed({18'd0, p32});

    always_comb
    begin
        case (cfg.value_kind)
            VK_PULSE:     val_next = $signed({8'd0, p32});
            VK_INTENSITY: val_next = $signed({8'd0, desc_reg.intensity, 16'd0});
            default:
            begin
                if ((dual_reg < p_wide) && (p32 < cfg.pulse_threshold))
                begin
                    val_next = $signed({8'd0, p32});
                end
                else if (dual_reg > SAT_HI)
                begin
                    val_next = SAT_HI[39:0];
                end
                else if (dual_reg < SAT_LO)
                begin
                    val_next = SAT_LO[39:0];
                end
                else
                begin
                    val_next = dual_reg[39:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            desc_reg      <= '0;
            col_reg       <= 6'd0;
            prod_reg      <= '0;
            dual_reg      <= '0;
            val_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // drop the taken transaction unless a new column replaces it
            if (!out_stall && !emit_now)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && (q_head.kind == DK_RUN))
                    begin
                        desc_reg <= q_head;
                        col_reg  <= q_head.first;
                        state_reg <= q_head.has_entry ? ST_MUL : ST_EMIT;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= $signed({1'b0, desc_reg.intensity}) * rd_slope_reg;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    dual_reg  <= DW'(prod_reg) + DW'(rd_icpt_reg);
                    state_reg <= ST_SEL;
                end
                ST_SEL:
                begin
                    val_reg   <= val_next;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.column      <= col_reg;
                        out_data_reg.value       <= (desc_reg.has_entry
                                                     && (col_reg == desc_reg.marker))
                                                    ? val_reg : 40'sd0;
                        out_data_reg.row_end     <= !desc_reg.flag
                                                    && ((col_ext + 7'd1) == desc_reg.row_len);
                        out_data_reg.run_end     <= (col_reg == desc_reg.last);
                        out_data_reg.order_error <= desc_reg.err;
                        col_reg <= col_reg + 6'd1;
                        if (col_reg == desc_reg.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `CRDE_ASSERT(a_pop_only_idle, clk, rst_n, q_pop |-> (state_reg == ST_IDLE), "queue popped while busy")
    `CRDE_ASSERT(a_emit_in_run, clk, rst_n, (state_reg == ST_EMIT) |-> (col_reg <= desc_reg.last), "column beyond run end")
    `CRDE_ASSERT(a_row_end_closes, clk, rst_n, (out_valid_reg && out_data_reg.row_end) |-> out_data_reg.run_end, "row end not last of run")
    `CRDE_NEVER(a_load_no_result, clk, rst_n, mem_wr && (state_reg != ST_IDLE), "table written while busy")

endmodule

`default_nettype wire

### src/csr_row_dense_expand_dual_count.sv
// Top level of the sparse row expander: configuration registers, APB port,
// front end, descriptor queue and back end. Depends on crde_pkg and submodules.
//
// Use: sparse entries of one push arrive on in_valid/in_stall in ascending
// marker order; dense values leave on out_valid/out_stall, one transaction per
// column, zero for absent markers, trailing zeros up to num_markers on close.
// Load items write per-marker slope and intercept and give no transaction.
// Path: each run passes the queue, the back end's emit state and the output
// register; a run holding an entry value first passes the 17x32 multiply, the
// add and the select stages before the emit state.
// Throughput: one dense column per cycle inside a run while the receiver does
// not stall; the back end takes a new item from the queue only in its idle
// state, after the last column of the previous run.
// Reset: registers return to 64 markers, dual count, threshold 0; the push
// starts at column 0; calibration tables hold no defined value until loaded.
// Receiver stall: the output register holds its transaction, the back end
// waits, the two-deep queue fills and in_stall then rises.
// Configuration: write only while idle; registers at byte addresses 0, 4, 8.
`default_nettype none

module csr_row_dense_expand_dual_count #(
    parameter int MAX_MARKERS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  crde_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output crde_pkg::out_item_t out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [3:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import crde_pkg::*;

    cfg_t  cfg_reg;
    desc_t q_data;
    desc_t q_head;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // take register writes in the access phase; unknown addresses drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_markers     <= RST_NUM_MARKERS;
            cfg_reg.value_kind      <= RST_VALUE_KIND;
            cfg_reg.pulse_threshold <= RST_PULSE_THRESHOLD;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_NUM_MARKERS:     cfg_reg.num_markers     <= pwdata[6:0];
                REG_VALUE_KIND:      cfg_reg.value_kind      <= pwdata[1:0];
                REG_PULSE_THRESHOLD: cfg_reg.pulse_threshold <= pwdata;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_MARKERS:     prdata = {25'd0, cfg_reg.num_markers};
            REG_VALUE_KIND:      prdata = {30'd0, cfg_reg.value_kind};
            REG_PULSE_THRESHOLD: prdata = cfg_reg.pulse_threshold;
            default:             prdata = 32'd0;
        endcase
    end

    // classify items and track the next column of the push
    crde_front #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (q_full),
        .in_stall (in_stall),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    // decouple the front from a stalled back end
    crde_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // expand runs into dense columns
    crde_back #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
